### sv/msrg_pkg.sv
// ----------------------------------------------------------------------------
// msrg_pkg
// Shared constants, opcodes and sequencer states of the multiply-shift
// random generator.
// ----------------------------------------------------------------------------
`default_nettype none

package msrg_pkg;

  localparam int WORD_W  = 32;
  localparam int STATE_W = 64;
  localparam int NUM_W   = 33;
  // After the last round the state is a 64-bit product shifted right by 16,
  // so only the low 48 bits can be set.
  localparam int DIV_W   = 48;
  localparam int SHIFT   = 16;

  localparam logic [STATE_W-1:0] GEN_INIT     = 64'h1234_5678_ABCD_EF11;
  localparam logic [WORD_W-1:0]  SEED_DEFAULT = 32'h1234_5678;
  localparam logic [WORD_W-1:0]  MUL_FIRST    = 32'h12AB_89CC;
  localparam logic [WORD_W-1:0]  MUL_ODD      = 32'hABCD_EF89;
  localparam logic [WORD_W-1:0]  MUL_EVEN     = 32'hA1B2_C3D4;
  localparam logic [WORD_W-1:0]  MUL_BIT3_SET = 32'h1234_FEDC;
  localparam logic [WORD_W-1:0]  MUL_BIT3_CLR = 32'h2F7A_9BC3;

  typedef enum logic [1:0] {
    ROUND_FIRST  = 2'd0,
    ROUND_SECOND = 2'd1,
    ROUND_THIRD  = 2'd2
  } round_t;

  typedef enum logic [1:0] {
    OP_RESEED = 2'd0,
    OP_DRAW_U = 2'd1,
    OP_DRAW_S = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_PREP,
    FSM_MUL_LO,
    FSM_MUL_HI,
    FSM_MOD_LAUNCH,
    FSM_MOD_WAIT,
    FSM_FINISH
  } fsm_t;

endpackage

`default_nettype wire

### sv/multiply_shift_random_generator_unit.sv
// ----------------------------------------------------------------------------
// multiply_shift_random_generator_unit
// 64-bit multiply-shift random generator with reseed, bounded unsigned draw
// and inclusive signed range draw.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-----------------------------------
//  in      | sink      | in_valid / in_stall | op, seed_value, upper_end, lower_end
//  out     | source    | out_valid/out_stall | number
//
//  Reseed: no result beat; the next beat is taken straight away.
//  Draw: form the bound, then three rounds on the single shared 32x32
//  multiplier (two halves per round), launch, 48 remainder steps and a
//  completion flag, then form the result.
//  Zero bound: skip multiplier and remainder; go from bound straight to result.
//  Synchronous reset loads the generator state with its initial constant.
//  in_stall is high while a draw is in progress; a result beat held by
//  out_stall holds the next draw in its finishing step.
// ----------------------------------------------------------------------------
`default_nettype none

module multiply_shift_random_generator_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        op,
  input  wire logic [msrg_pkg::WORD_W-1:0]       seed_value,
  input  wire logic signed [msrg_pkg::NUM_W-1:0] upper_end,
  input  wire logic signed [msrg_pkg::WORD_W-1:0] lower_end,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [msrg_pkg::NUM_W-1:0]      number
);
  import msrg_pkg::*;

  fsm_t fsm, fsm_next;

  logic [STATE_W-1:0] gstate;   // generator state
  op_t                op_q;
  logic [WORD_W-1:0]  lo_q;     // range minimum, zero for unsigned draws
  logic [WORD_W-1:0]  hi_q;     // range maximum, or the bound itself
  logic [WORD_W-1:0]  bound;
  logic [WORD_W-1:0]  draw;
  round_t             round;
  logic [STATE_W-1:0] p0;       // low-half partial product

  logic               accept;
  logic               mod_start;
  logic               mod_done;
  logic [WORD_W-1:0]  mod_rem;
  logic               load_out;

  logic [WORD_W-1:0]  upper32;
  logic               swap;
  logic [WORD_W-1:0]  width;
  logic [WORD_W-1:0]  bound_next;
  logic [WORD_W-1:0]  mul_a;
  logic [WORD_W-1:0]  mul_b;
  logic [STATE_W-1:0] prod;
  logic [STATE_W-1:0] sum;
  logic [WORD_W-1:0]  res;
  logic [NUM_W-1:0]   number_next;

  assign in_stall = (fsm != FSM_IDLE);
  assign accept   = in_valid && !in_stall;

  // order the signed range as the beat comes in
  assign upper32 = upper_end[WORD_W-1:0];
  assign swap    = $signed(lower_end) > $signed(upper32);

  // range width with 32-bit wrap, then its magnitude
  assign width      = hi_q + WORD_W'(1) - lo_q;
  assign bound_next = (op_q == OP_DRAW_S) ? (width[WORD_W-1] ? (-width) : width) : hi_q;

  // shared multiplier: low half of the state, then the high half
  assign mul_a = (fsm == FSM_MUL_HI) ? gstate[STATE_W-1:WORD_W] : gstate[WORD_W-1:0];

  always_comb begin
    unique case (round)
      ROUND_FIRST:  mul_b = MUL_FIRST;
      ROUND_SECOND: mul_b = gstate[0] ? MUL_ODD : MUL_EVEN;
      ROUND_THIRD:  mul_b = gstate[3] ? MUL_BIT3_SET : MUL_BIT3_CLR;
      default:      mul_b = MUL_FIRST;
    endcase
  end

  assign prod = STATE_W'(mul_a) * STATE_W'(mul_b);
  // product modulo 2^64: the high half only adds its low word shifted up
  assign sum  = p0 + {prod[WORD_W-1:0], {WORD_W{1'b0}}};

  // offset by the minimum with 32-bit wrap; sign-extend signed draws
  assign res         = lo_q + draw;
  assign number_next = (op_q == OP_DRAW_S) ? {res[WORD_W-1], res} : {1'b0, res};

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= FSM_IDLE;
    end else begin
      fsm <= fsm_next;
    end
  end

  always_comb begin
    fsm_next  = fsm;
    mod_start = 1'b0;
    load_out  = 1'b0;
    unique case (fsm)
      FSM_IDLE: begin
        if (accept && (op_t'(op) == OP_DRAW_U || op_t'(op) == OP_DRAW_S)) begin
          fsm_next = FSM_PREP;
        end
      end
      FSM_PREP: begin
        fsm_next = (bound_next == '0) ? FSM_FINISH : FSM_MUL_LO;
      end
      FSM_MUL_LO: begin
        fsm_next = FSM_MUL_HI;
      end
      FSM_MUL_HI: begin
        fsm_next = (round == ROUND_THIRD) ? FSM_MOD_LAUNCH : FSM_MUL_LO;
      end
      FSM_MOD_LAUNCH: begin
        mod_start = 1'b1;
        fsm_next  = FSM_MOD_WAIT;
      end
      FSM_MOD_WAIT: begin
        if (mod_done) begin
          fsm_next = FSM_FINISH;
        end
      end
      FSM_FINISH: begin
        // hold here while the previous result beat is still stalled
        if (!out_valid || !out_stall) begin
          load_out = 1'b1;
          fsm_next = FSM_IDLE;
        end
      end
      default: fsm_next = FSM_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Generator state and draw datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      gstate <= GEN_INIT;
    end else if (accept && op_t'(op) == OP_RESEED) begin
      // a zero seed would lock the generator; substitute the default
      gstate <= {{(STATE_W-WORD_W){1'b0}},
                 (seed_value == '0) ? SEED_DEFAULT : seed_value};
    end else if (fsm == FSM_PREP && gstate == '0) begin
      gstate <= GEN_INIT;
    end else if (fsm == FSM_MUL_HI) begin
      gstate <= {{SHIFT{1'b0}}, sum[STATE_W-1:SHIFT]};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= op_t'(op);
      if (op_t'(op) == OP_DRAW_S) begin
        lo_q <= swap ? upper32 : lower_end;
        hi_q <= swap ? lower_end : upper32;
      end else begin
        lo_q <= '0;
        hi_q <= upper32;
      end
    end
    if (fsm == FSM_PREP) begin
      bound <= bound_next;
      round <= ROUND_FIRST;
      draw  <= '0;
    end
    if (fsm == FSM_MUL_LO) begin
      p0 <= prod;
    end
    if (fsm == FSM_MUL_HI && round != ROUND_THIRD) begin
      round <= round_t'(round + 2'd1);
    end
    if (fsm == FSM_MOD_WAIT && mod_done) begin
      draw <= mod_rem;
    end
  end

  msrg_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (gstate[DIV_W-1:0]),
    .divisor   (bound),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // --------------------------------------------------------------------------
  // Output register: holds the result beat while the sink stalls
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      number <= $signed(number_next);
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_mod_bound_nonzero: assert property (@(posedge clk) disable iff (rst)
    mod_start |-> (bound != '0))
    else $error("remainder unit launched with zero bound");

  a_dividend_fits: assert property (@(posedge clk) disable iff (rst)
    (fsm == FSM_MOD_WAIT) |-> (gstate[STATE_W-1:DIV_W] == '0))
    else $error("state wider than remainder dividend");

  a_result_after_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(fsm == FSM_FINISH))
    else $error("result beat raised outside finishing step");

endmodule

`default_nettype wire

### sv/msrg_mod.sv
// ----------------------------------------------------------------------------
// msrg_mod
// Serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msrg_mod (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [msrg_pkg::DIV_W-1:0]  dividend,
  input  wire logic [msrg_pkg::WORD_W-1:0] divisor,
  output logic                             done,
  output logic [msrg_pkg::WORD_W-1:0]      remainder
);
  import msrg_pkg::*;

  localparam int CntW = $clog2(DIV_W + 1);

  logic              busy;
  logic [CntW-1:0]   count;
  logic [DIV_W-1:0]  shreg;
  logic [WORD_W-1:0] dsor;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;

  // shift the next dividend bit into the partial remainder
  assign trial = {remainder, shreg[DIV_W-1]};
  assign diff  = trial - {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy && (count == CntW'(1));
      if (start) begin
        busy  <= 1'b1;
        count <= CntW'(DIV_W);
      end else if (busy) begin
        count <= count - CntW'(1);
        if (count == CntW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= dividend;
      dsor      <= divisor;
      remainder <= '0;
    end else if (busy) begin
      shreg <= {shreg[DIV_W-2:0], 1'b0};
      // keep the trial value when the divisor does not fit
      remainder <= diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (remainder < dsor))
    else $error("remainder not below divisor");

  a_no_restart_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("remainder unit restarted while busy");

endmodule

`default_nettype wire
